// ===== hdl/sln_pkg.sv =====
package sln_pkg;

	localparam int unsigned SIZE_W     = 31;
	localparam int unsigned IDX_W      = 32;
	localparam int unsigned COUNT_W    = 31;
	localparam int unsigned OFFS_W     = 63;
	localparam int unsigned DIV_STEPS  = COUNT_W;
	localparam int unsigned IN_DATA_W  = 160;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 192;
	localparam int unsigned OUT_USER_W = 1;

	// error codes
	localparam logic ERR_NONE      = 1'b0;
	localparam logic ERR_ZERO_STEP = 1'b1;

	// bounds after wrap and clamp
	typedef struct packed {
		logic [SIZE_W-1:0]       start;
		logic signed [IDX_W-1:0] stop;
		logic signed [IDX_W-1:0] step;
		logic signed [IDX_W-1:0] stride;
		logic                    error_code;
		logic                    count_zero;
	} sln_nrm_t;

	// fields that ride alongside the divider
	typedef struct packed {
		logic [SIZE_W-1:0]        norm_start;
		logic signed [IDX_W-1:0]  norm_stop;
		logic signed [IDX_W-1:0]  norm_step;
		logic signed [OFFS_W-1:0] start_offset;
		logic                     error_code;
		logic                     count_zero;
	} sln_res_t;

	// divider working set: dividend bits shift out as quotient bits shift in
	typedef struct packed {
		logic [IDX_W-1:0]   rem;
		logic [COUNT_W-1:0] dq;
		logic [IDX_W-1:0]   divisor;
	} sln_div_t;

endpackage

// ===== hdl/sln_norm.sv =====
module sln_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sln_pkg::SIZE_W-1:0]        dim_len,
	input  logic                              start_given,
	input  logic signed [sln_pkg::IDX_W-1:0]  start_index,
	input  logic                              stop_given,
	input  logic signed [sln_pkg::IDX_W-1:0]  stop_index,
	input  logic signed [sln_pkg::IDX_W-1:0]  step_value,
	input  logic signed [sln_pkg::IDX_W-1:0]  mem_stride,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sln_pkg::sln_nrm_t                 out_data
);
	import sln_pkg::*;

	logic signed [IDX_W:0] size_x;
	logic signed [IDX_W:0] hi_s;
	logic signed [IDX_W:0] start_x;
	logic signed [IDX_W:0] stop_x;
	logic signed [IDX_W:0] s_raw;
	logic signed [IDX_W:0] s_clip;
	logic signed [IDX_W:0] s_fin;
	logic signed [IDX_W:0] e_raw;
	logic signed [IDX_W:0] e_hi;
	logic signed [IDX_W:0] e_lo;
	logic signed [IDX_W:0] e_clip;
	logic signed [IDX_W:0] e_fin;
	logic                  step_neg;
	logic                  step_zero;
	logic                  valid_s1;
	sln_nrm_t              data_s1;
	sln_nrm_t              nxt;

	assign size_x    = signed'({2'b00, dim_len});
	assign hi_s      = size_x - (IDX_W+1)'(1);
	assign start_x   = {start_index[IDX_W-1], start_index};
	assign stop_x    = {stop_index[IDX_W-1], stop_index};
	assign step_neg  = step_value[IDX_W-1];
	assign step_zero = (step_value == '0);

	always_comb begin
		// start: wrap, clip high, then low wins
		s_raw  = start_index[IDX_W-1] ? start_x + size_x : start_x;
		s_clip = (s_raw > hi_s) ? hi_s : s_raw;
		if (s_clip < 0) begin
			s_clip = '0;
		end
		if (start_given) begin
			s_fin = s_clip;
		end else if (step_neg && dim_len != '0) begin
			s_fin = hi_s;
		end else begin
			s_fin = '0;
		end

		// stop bounds depend on step direction
		e_hi   = step_neg ? hi_s : size_x;
		e_lo   = step_neg ? '1 : '0;
		e_raw  = stop_index[IDX_W-1] ? stop_x + size_x : stop_x;
		e_clip = (e_raw > e_hi) ? e_hi : e_raw;
		if (e_clip < e_lo) begin
			e_clip = e_lo;
		end
		if (stop_given) begin
			e_fin = e_clip;
		end else begin
			e_fin = step_neg ? '1 : size_x;
		end

		nxt.start      = step_zero ? '0 : s_fin[SIZE_W-1:0];
		nxt.stop       = step_zero ? '0 : e_fin[IDX_W-1:0];
		nxt.step       = step_value;
		nxt.stride     = mem_stride;
		nxt.error_code = step_zero ? ERR_ZERO_STEP : ERR_NONE;
		nxt.count_zero = step_zero || (dim_len == '0);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== hdl/sln_prep.sv =====
module sln_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sln_pkg::sln_nrm_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sln_pkg::sln_res_t out_res,
	output sln_pkg::sln_div_t out_div
);
	import sln_pkg::*;

	logic signed [2*IDX_W-1:0] prod;
	logic signed [IDX_W:0]     start_x;
	logic signed [IDX_W:0]     stop_x;
	logic signed [IDX_W:0]     span_m1;
	logic                      step_neg;
	logic                      valid_s2;
	sln_res_t                  res_nxt;
	sln_div_t                  div_nxt;
	sln_res_t                  res_s2;
	sln_div_t                  div_s2;

	assign prod     = $signed({1'b0, in_data.start}) * in_data.stride;
	assign start_x  = signed'({2'b00, in_data.start});
	assign stop_x   = {in_data.stop[IDX_W-1], in_data.stop};
	assign step_neg = in_data.step[IDX_W-1];

	// count = (span - 1) / |step| + 1 when span is positive
	assign span_m1 = step_neg ? start_x - stop_x - (IDX_W+1)'(1)
	                          : stop_x - start_x - (IDX_W+1)'(1);

	always_comb begin
		res_nxt.norm_start   = in_data.start;
		res_nxt.norm_stop    = in_data.stop;
		res_nxt.norm_step    = in_data.step;
		res_nxt.start_offset = prod[OFFS_W-1:0];
		res_nxt.error_code   = in_data.error_code;
		res_nxt.count_zero   = in_data.count_zero || span_m1[IDX_W];
		div_nxt.rem          = '0;
		div_nxt.dq           = span_m1[COUNT_W-1:0];
		div_nxt.divisor      = step_neg ? (~in_data.step + IDX_W'(1)) : in_data.step;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_s2 <= res_nxt;
			div_s2 <= div_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;
	assign out_div   = div_s2;

endmodule

// ===== hdl/sln_div_cell.sv =====
module sln_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sln_pkg::sln_res_t in_res,
	input  sln_pkg::sln_div_t in_div,
	output logic              out_valid,
	input  logic              out_ready,
	output sln_pkg::sln_res_t out_res,
	output sln_pkg::sln_div_t out_div
);
	import sln_pkg::*;

	logic [IDX_W+1:0] diff;
	logic             fits;
	sln_div_t         div_nxt;
	logic             valid_q;
	sln_res_t         res_q;
	sln_div_t         div_q;

	// one restoring step: bring down the next dividend bit, try the subtract
	assign diff = {1'b0, in_div.rem, in_div.dq[COUNT_W-1]} - {2'b00, in_div.divisor};
	assign fits = !diff[IDX_W+1];

	always_comb begin
		div_nxt.divisor = in_div.divisor;
		div_nxt.rem     = fits ? diff[IDX_W-1:0]
		                       : {in_div.rem[IDX_W-2:0], in_div.dq[COUNT_W-1]};
		div_nxt.dq      = {in_div.dq[COUNT_W-2:0], fits};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
			div_q <= div_nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_div   = div_q;

endmodule

// ===== hdl/slice_index_normalizer.sv =====
// Slice index normalizer: takes one slice request (size, optional start and stop, step,
// stride) per transfer and returns the wrapped and clamped bounds, the element count and
// the start offset start * stride, with error code 1 and all-zero fields for a zero step.
// A new request can be taken every cycle when nothing stalls; each one passes through
// one clamp stage, one stage with the offset multiplier and span subtract, a chain of 31
// divider cells that each produce one bit of the count quotient, and the output register.
// Ready passes combinationally back through every stage, so empty stages keep filling
// during an output stall and the input stops in the same cycle once all 34 stages hold
// an item.
module slice_index_normalizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// dim_len, start_index, stop_index, step_value, mem_stride, zero pad
	input  logic [sln_pkg::IN_DATA_W-1:0]     s_tdata,
	// start_given, stop_given
	input  logic [sln_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// norm_start, norm_stop, norm_step, element_count, start_offset, zero pad
	output logic [sln_pkg::OUT_DATA_W-1:0]    m_tdata,
	// error_code
	output logic [sln_pkg::OUT_USER_W-1:0]    m_tuser
);
	import sln_pkg::*;

	localparam int unsigned PAD_W = OUT_DATA_W - (SIZE_W + 2*IDX_W + COUNT_W + OFFS_W);

	logic              nrm_valid;
	logic              nrm_ready;
	sln_nrm_t          nrm_data;

	logic              chain_valid [0:DIV_STEPS];
	logic              chain_ready [0:DIV_STEPS];
	sln_res_t          chain_res   [0:DIV_STEPS];
	sln_div_t          chain_div   [0:DIV_STEPS];

	logic              out_valid_q;
	logic              out_load;
	sln_res_t          out_res_q;
	logic [COUNT_W-1:0] out_count_q;
	sln_res_t          last_res;
	sln_div_t          last_div;

	sln_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.dim_len     (s_tdata[SIZE_W-1:0]),
		.start_given (s_tuser[0]),
		.start_index (s_tdata[SIZE_W +: IDX_W]),
		.stop_given  (s_tuser[1]),
		.stop_index  (s_tdata[SIZE_W+IDX_W +: IDX_W]),
		.step_value  (s_tdata[SIZE_W+2*IDX_W +: IDX_W]),
		.mem_stride  (s_tdata[SIZE_W+3*IDX_W +: IDX_W]),
		.out_valid   (nrm_valid),
		.out_ready   (nrm_ready),
		.out_data    (nrm_data)
	);

	sln_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nrm_valid),
		.in_ready  (nrm_ready),
		.in_data   (nrm_data),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_res   (chain_res[0]),
		.out_div   (chain_div[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		sln_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_res    (chain_res[i]),
			.in_div    (chain_div[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_res   (chain_res[i+1]),
			.out_div   (chain_div[i+1])
		);
	end

	assign last_res = chain_res[DIV_STEPS];
	assign last_div = chain_div[DIV_STEPS];

	// output register
	assign out_load               = !out_valid_q || m_tready;
	assign chain_ready[DIV_STEPS] = out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= chain_valid[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && chain_valid[DIV_STEPS]) begin
			out_res_q   <= last_res;
			out_count_q <= last_res.count_zero ? '0 : last_div.dq + COUNT_W'(1);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_res_q.start_offset, out_count_q,
	                   out_res_q.norm_step, out_res_q.norm_stop, out_res_q.norm_start};
	assign m_tuser  = out_res_q.error_code;

endmodule

// ===== hdl/sln_checker.sv =====
module sln_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sln_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic [sln_pkg::OUT_USER_W-1:0]    m_tuser
);
	import sln_pkg::*;

	localparam int unsigned STOP_LSB = SIZE_W;
	localparam int unsigned STEP_LSB = SIZE_W + IDX_W;
	localparam int unsigned USED_W   = SIZE_W + 2*IDX_W + COUNT_W + OFFS_W;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// zero step gives an all-zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == ERR_ZERO_STEP |-> m_tdata[USED_W-1:0] == '0)
		else $error("zero step result has nonzero fields");

	// a good result never carries a zero step
	a_ok_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == ERR_NONE |-> m_tdata[STEP_LSB +: IDX_W] != '0)
		else $error("zero step without error code");

	// normalized stop never below minus one
	a_stop_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[STOP_LSB+IDX_W-1] || m_tdata[STOP_LSB +: IDX_W] == '1)
		else $error("normalized stop below minus one");

endmodule

bind slice_index_normalizer sln_checker u_sln_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
